// ===== hdl/fqtp_pkg.sv =====
// Shared constants, codes and types for the threshold-purge queue.
`default_nettype none
package fqtp_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned S_DATA_W    = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned M_DATA_W    = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W     = M_DATA_W - VALUE_WIDTH - CNT_W;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // per-cell controls driven by the sequencer
  typedef struct packed {
    logic [QUEUE_DEPTH-1:0] shift;
    logic [QUEUE_DEPTH-1:0] load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/fqtp_cell.sv =====
// One queue cell: holds one entry, takes its right neighbor's value on shift.
`default_nettype none
module fqtp_cell (
  input  wire                  clk_i,
  input  wire                  shift_i,
  input  wire                  load_i,
  input  wire fqtp_pkg::value_t nb_data_i,
  input  wire fqtp_pkg::value_t new_data_i,
  input  wire fqtp_pkg::value_t thr_i,
  output fqtp_pkg::value_t     data_o,
  output logic                 above_o
);

  fqtp_pkg::value_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = new_data_i;
    end else if (shift_i) begin
      data_d = nb_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign above_o = $signed(data_q) > $signed(thr_i);

endmodule
`default_nettype wire

// ===== hdl/fifo_queue_with_threshold_purge_unit.sv =====
// Top level: sequencer and output register over a row of queue cells.
//
//  channel  dir  tdata (low bit up)                    tuser
//  s_axis   in   operand_value[31:0]                   operation[1:0]
//  m_axis   out  popped_value[31:0], entry_count[4:0]  status[1:0]
//
// Push, pop and no-op finish in the accept cycle: one item per cycle while the output is free.
// Purge scans one cell per cycle from the entry behind the head; a removal shifts
// the cells behind it left by one and holds the scan; busy until the result is registered.
// Reset clears counts and control; cell contents are not reset.
// Input waits while a purge runs or a stalled result holds the output register.
`default_nettype none
module fifo_queue_with_threshold_purge_unit (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [fqtp_pkg::S_DATA_W-1:0]        s_axis_tdata,  // operand_value
  input  wire  [fqtp_pkg::OP_W-1:0]            s_axis_tuser,  // operation
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [fqtp_pkg::M_DATA_W-1:0]        m_axis_tdata,  // popped_value, entry_count
  output logic [fqtp_pkg::STAT_W-1:0]          m_axis_tuser   // status
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PURGE = 1'b1;

  logic                              state_q, state_d;
  logic [fqtp_pkg::CNT_W-1:0]        count_q, count_d;
  logic [fqtp_pkg::CNT_W-1:0]        scan_q, scan_d;
  fqtp_pkg::value_t                  thr_q, thr_d;
  logic                              out_valid_q, out_valid_d;
  fqtp_pkg::value_t                  out_pop_q, out_pop_d;
  logic [fqtp_pkg::STAT_W-1:0]       out_stat_q, out_stat_d;
  logic [fqtp_pkg::CNT_W-1:0]        out_cnt_q, out_cnt_d;

  fqtp_pkg::cell_ctrl_t              ctrl;
  fqtp_pkg::value_t                  cell_data [fqtp_pkg::QUEUE_DEPTH];
  logic [fqtp_pkg::QUEUE_DEPTH-1:0]  cell_above;
  fqtp_pkg::value_t                  in_value;
  logic                              out_free;
  logic                              in_xfer;

  assign in_value = s_axis_tdata[fqtp_pkg::VALUE_WIDTH-1:0];
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < fqtp_pkg::QUEUE_DEPTH; g++) begin : g_cell
    fqtp_pkg::value_t nb;
    if (g == fqtp_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign nb = cell_data[g];
    end else begin : g_mid
      assign nb = cell_data[g+1];
    end
    fqtp_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ctrl.shift[g]),
      .load_i     (ctrl.load[g]),
      .nb_data_i  (nb),
      .new_data_i (in_value),
      .thr_i      (thr_q),
      .data_o     (cell_data[g]),
      .above_o    (cell_above[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    thr_d       = thr_q;
    out_valid_d = out_valid_q;
    out_pop_d   = out_pop_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;
    ctrl        = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          out_pop_d  = '0;
          out_stat_d = fqtp_pkg::STAT_OK;
          unique case (s_axis_tuser)
            fqtp_pkg::OP_PUSH: begin
              if (count_q >= fqtp_pkg::CNT_W'(fqtp_pkg::QUEUE_DEPTH)) begin
                out_stat_d = fqtp_pkg::STAT_FULL;
              end else begin
                for (int i = 0; i < fqtp_pkg::QUEUE_DEPTH; i++) begin
                  ctrl.load[i] = (count_q[fqtp_pkg::IDX_W-1:0] == fqtp_pkg::IDX_W'(i));
                end
                count_d = count_q + 1'b1;
              end
            end
            fqtp_pkg::OP_POP: begin
              if (count_q == '0) begin
                out_stat_d = fqtp_pkg::STAT_EMPTY;
              end else begin
                out_pop_d  = cell_data[0];
                ctrl.shift = '1;
                count_d    = count_q - 1'b1;
              end
            end
            fqtp_pkg::OP_PURGE: begin
              thr_d   = in_value;
              scan_d  = fqtp_pkg::CNT_W'(1);
              state_d = ST_PURGE;
            end
            default: ;
          endcase
          if (s_axis_tuser != fqtp_pkg::OP_PURGE) begin
            out_valid_d = 1'b1;
            out_cnt_d   = count_d;
          end
        end
      end
      ST_PURGE: begin
        if (scan_q >= count_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_cnt_d   = count_q;
            state_d     = ST_IDLE;
          end
        end else if (cell_above[scan_q[fqtp_pkg::IDX_W-1:0]]) begin
          // drop this entry: everything behind it moves up one cell
          for (int i = 0; i < fqtp_pkg::QUEUE_DEPTH; i++) begin
            ctrl.shift[i] = (fqtp_pkg::CNT_W'(i) >= scan_q);
          end
          count_d = count_q - 1'b1;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q      <= thr_d;
    out_pop_q  <= out_pop_d;
    out_stat_q <= out_stat_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{fqtp_pkg::M_PAD_W{1'b0}}, out_cnt_q, out_pop_q};
  assign m_axis_tuser  = out_stat_q;

endmodule
`default_nettype wire

// ===== dv/fifo_queue_with_threshold_purge_unit_tb.sv =====
// Testbench for the threshold-purge queue: result scoreboard and stream drivers.
class queue_scoreboard;
  typedef struct {
    fqtp_pkg::value_t              popped;
    logic [fqtp_pkg::STAT_W-1:0]   status;
    logic [fqtp_pkg::CNT_W-1:0]    count;
  } outcome_t;

  fqtp_pkg::value_t ring [fqtp_pkg::QUEUE_DEPTH];
  int unsigned      head_idx;
  int unsigned      tail_idx;
  int unsigned      held;
  outcome_t         outcome_q[$];
  int unsigned      errors;

  function new();
    head_idx = 0;
    tail_idx = 0;
    held     = 0;
    errors   = 0;
  endfunction

  function int unsigned next_slot(int unsigned i);
    return (i + 1) % fqtp_pkg::QUEUE_DEPTH;
  endfunction

  // k-th entry counted from the head; only held entries are ever asked for
  function fqtp_pkg::value_t stored(int unsigned k);
    return ring[(head_idx + k) % fqtp_pkg::QUEUE_DEPTH];
  endfunction

  function int unsigned pending();
    return outcome_q.size();
  endfunction

  // drops every entry behind the head that is above the threshold and compacts the rest
  function void purge_above(fqtp_pkg::value_t limit);
    int unsigned      rd;
    int unsigned      wr;
    int unsigned      kept;
    fqtp_pkg::value_t v;
    if (held < 2) return;
    rd   = next_slot(head_idx);
    wr   = rd;
    kept = 1;
    for (int unsigned k = 1; k < held; k++) begin
      v = ring[rd];
      if (!($signed(v) > $signed(limit))) begin
        ring[wr] = v;
        wr       = next_slot(wr);
        kept++;
      end
      rd = next_slot(rd);
    end
    held     = kept;
    tail_idx = wr;
  endfunction

  function void note_input(logic [fqtp_pkg::OP_W-1:0] op, fqtp_pkg::value_t val);
    outcome_t o;
    o.popped = '0;
    o.status = fqtp_pkg::STAT_OK;
    case (op)
      fqtp_pkg::OP_PUSH: begin
        if (held >= fqtp_pkg::QUEUE_DEPTH) begin
          o.status = fqtp_pkg::STAT_FULL;
        end else begin
          ring[tail_idx] = val;
          tail_idx       = next_slot(tail_idx);
          held++;
        end
      end
      fqtp_pkg::OP_POP: begin
        if (held == 0) begin
          o.status = fqtp_pkg::STAT_EMPTY;
        end else begin
          o.popped = ring[head_idx];
          head_idx = next_slot(head_idx);
          held--;
        end
      end
      fqtp_pkg::OP_PURGE: purge_above(val);
      default: ;
    endcase
    o.count = held[fqtp_pkg::CNT_W-1:0];
    outcome_q.push_back(o);
  endfunction

  function void check_result(fqtp_pkg::value_t popped, logic [fqtp_pkg::CNT_W-1:0] cnt,
                             logic [fqtp_pkg::STAT_W-1:0] stat);
    outcome_t want;
    if (outcome_q.size() == 0) begin
      $error("result transfer with nothing outstanding: popped_value %0d", $signed(popped));
      errors++;
      return;
    end
    want = outcome_q.pop_front();
    if (popped !== want.popped) begin
      $error("popped_value: expected %0d, got %0d", $signed(want.popped), $signed(popped));
      errors++;
    end
    if (stat !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, stat);
      errors++;
    end
    if (cnt !== want.count) begin
      $error("entry_count: expected %0d, got %0d", want.count, cnt);
      errors++;
    end
  endfunction
endclass

module fifo_queue_with_threshold_purge_unit_tb;
  import fqtp_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE     = 2'd3;  // unused code, acts as a no-op
  localparam int unsigned     CYCLE_LIMIT = 400000;
  localparam int unsigned     RANDOM_ITEMS = 210;  // per idle phase

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;

  int unsigned     send_idle = 0;
  int unsigned     recv_idle = 0;
  int unsigned     cycle_count = 0;
  int unsigned     mode = 0;
  queue_scoreboard sb = new();

  fifo_queue_with_threshold_purge_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // sample mid-cycle; a transfer seen here completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[VALUE_WIDTH-1:0], m_axis_tdata[VALUE_WIDTH +: CNT_W],
                      m_axis_tuser);
  end

  task automatic send_item(logic [OP_W-1:0] op, value_t val);
    bit fire;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    do begin
      @(negedge clk_i);
      fire = s_axis_tready;
      @(posedge clk_i);
    end while (!fire);
    sb.note_input(op, val);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // extremes, a cluster of small values so thresholds bite, and full-range noise
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return value_t'($signed($urandom_range(200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_run(int unsigned n);
    int unsigned     r;
    logic [OP_W-1:0] op;
    value_t          val;
    for (int unsigned i = 0; i < n; i++) begin
      // fill, drain and mixed stretches; a full queue tends to flip into draining
      if ($urandom_range(19) == 0 || (mode == 0 && sb.held == QUEUE_DEPTH && $urandom_range(3) == 0))
        mode = $urandom_range(2);
      r = $urandom_range(99);
      case (mode)
        0:       op = (r < 70) ? OP_PUSH : (r < 80) ? OP_POP : (r < 96) ? OP_PURGE : OP_NONE;
        1:       op = (r < 65) ? OP_POP : (r < 80) ? OP_PUSH : (r < 96) ? OP_PURGE : OP_NONE;
        default: op = (r < 40) ? OP_PUSH : (r < 75) ? OP_POP : (r < 95) ? OP_PURGE : OP_NONE;
      endcase
      if (op == OP_PURGE && sb.held > 0 && $urandom_range(1) == 0)
        val = sb.stored($urandom_range(sb.held - 1));
      else
        val = pick_value();
      send_item(op, val);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corner cases
    send_item(OP_POP, 32'h1234_5678);
    send_item(OP_PURGE, 32'h8000_0000);
    send_item(OP_NONE, 32'hFFFF_FFFF);
    // one entry: purge leaves the head alone
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PURGE, 32'h8000_0000);
    // purge drops the middle entries, later pushes must append after the surviving tail
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_PURGE, 32'hFFFF_FFFF);
    // fill to the top and push once more into a full queue
    for (int i = 0; i < 15; i++) send_item(OP_PUSH, pick_value());
    send_item(OP_PURGE, 32'h8000_0000);
    send_item(OP_POP, '0);
    wait_for_drain();

    send_idle = 19;
    recv_idle = 57;
    random_run(RANDOM_ITEMS);
    wait_for_drain();

    send_idle = 57;
    recv_idle = 19;
    random_run(RANDOM_ITEMS);
    wait_for_drain();

    send_idle = 0;
    recv_idle = 0;
    random_run(RANDOM_ITEMS);
    wait_for_drain();

    // idle after the drain so that a stray extra result would still be flagged
    repeat (4 * QUEUE_DEPTH) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== fifo_queue_with_threshold_purge_unit.f =====
hdl/fqtp_pkg.sv
hdl/fqtp_cell.sv
hdl/fifo_queue_with_threshold_purge_unit.sv
dv/fifo_queue_with_threshold_purge_unit_tb.sv
